@@ hw/rtl/mcs_pkg.sv @@
// Shared constants, types and the sine table generator for the metronome click synthesizer.
package mcs_pkg;

	// Fixed field widths
	localparam int LEN_W      = 16;
	localparam int INC_W      = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int OUT_W      = 15;
	localparam int QUO_W      = 14;
	localparam int Q_SHIFT    = 15;
	localparam int CNT_W      = 4;
	localparam int TAB_W      = 24;

	localparam logic [QUO_W-1:0] OUT_LIMIT = 14'd8192;

	// Register reset values
	localparam logic [LEN_W-1:0] CLICK_LENGTH_RST     = 16'd1323;
	localparam logic [INC_W-1:0] NORMAL_INCREMENT_RST = 32'd101920265;
	localparam logic [INC_W-1:0] ACCENT_INCREMENT_RST = 32'd152612555;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLICK_LENGTH = 2'd0,
		REG_NORMAL_INC   = 2'd1,
		REG_ACCENT_INC   = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_MUL,
		ST_NORM,
		ST_DIV,
		ST_DONE
	} mcs_state_t;

	// Quarter-wave sine magnitude for table index kk, evaluated at elaboration.
	// Q30 odd Taylor series up to x^9, rounded to the sample amplitude.
	function automatic logic [TAB_W-1:0] sine_mag(int unsigned kk, int unsigned addr_bits,
			int unsigned sample_bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] s;
		logic [63:0] amp;
		logic [63:0] v;
		x   = (64'(kk) * HALF_PI_Q30 + (64'd1 << (addr_bits - 3))) >> (addr_bits - 2);
		x2  = (x * x) >> 30;
		pos = x;
		neg = 64'd0;
		t   = x;
		t   = ((t * x2) >> 30) / 64'd6;
		neg = neg + t;
		t   = ((t * x2) >> 30) / 64'd20;
		pos = pos + t;
		t   = ((t * x2) >> 30) / 64'd42;
		neg = neg + t;
		t   = ((t * x2) >> 30) / 64'd72;
		pos = pos + t;
		s   = (pos > neg) ? (pos - neg) : 64'd0;
		amp = (64'd1 << (sample_bits - 1)) - 64'd1;
		v   = (s * amp + (64'd1 << 29)) >> 30;
		if (v > amp) begin
			v = amp;
		end
		return v[TAB_W-1:0];
	endfunction

endpackage

@@ hw/rtl/metronome_click_synth.sv @@
// Metronome click synthesizer: decaying sine tick, one result item per input item.
// A sounding sample passes through the look-up, multiply, normalize and divide states; a silent
// one goes straight to the done state. The 16-step bit-serial envelope multiply and the 14-step
// bit-serial divide share one step counter. A new item is taken only in the idle state.
// A finished result waits in the output register while the next item is taken.
// Reset (arst_n low, asynchronous) clears the count, phase and step, and loads register defaults.
module metronome_click_synth #(
	parameter int PHASE_BITS     = 32,
	parameter int SINE_ADDR_BITS = 10,
	parameter int SAMPLE_BITS    = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mcs_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mcs_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  trigger,
	input  logic                                  accent,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [mcs_pkg::OUT_W-1:0]      click_sample,
	output logic                                  sounding
);
	import mcs_pkg::*;

	localparam int MAG_IN_W = SAMPLE_BITS - 1;
	localparam int MAG_W    = MAG_IN_W + LEN_W;
	localparam int NUM_W    = MAG_W + Q_SHIFT + 1;
	localparam int NH_W     = NUM_W - SAMPLE_BITS - 1;
	localparam int KK_W     = SINE_ADDR_BITS - 1;
	localparam int QUARTER  = 2 ** (SINE_ADDR_BITS - 2);

	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(LEN_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

	// Configuration registers
	logic [LEN_W-1:0] click_length_q;
	logic [INC_W-1:0] normal_inc_q;
	logic [INC_W-1:0] accent_inc_q;

	// Synth state
	logic [LEN_W-1:0]      samples_rem_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [INC_W-1:0]      active_inc_q;

	mcs_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             item_snd_q;

	// Datapath registers
	logic [MAG_IN_W-1:0] sine_mag_q;
	logic                sine_neg_q;
	logic [MAG_W-1:0]    prod_q;
	logic [LEN_W-1:0]    div_rem_q;
	logic [QUO_W-1:0]    div_sh_q;
	logic                ovf_q;

	// Output register
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] click_sample_q;
	logic                    sounding_q;

	// Control
	logic in_accept;
	logic out_free;
	logic out_load;
	logic snd_next;

	// Quarter-wave sine table
	logic [MAG_IN_W-1:0] qtab [QUARTER+1];

	for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
		localparam logic [TAB_W-1:0] TAB_V = sine_mag(g, SINE_ADDR_BITS, SAMPLE_BITS);
		assign qtab[g] = TAB_V[MAG_IN_W-1:0];
	end

	// Fold the phase address onto the quarter wave
	logic [SINE_ADDR_BITS-1:0] sine_addr;
	logic [KK_W-1:0]           kk0;
	logic [KK_W-1:0]           kk;

	assign sine_addr = phase_q[PHASE_BITS-1 -: SINE_ADDR_BITS];
	assign kk0       = sine_addr[KK_W-1:0];
	assign kk        = (kk0 > KK_W'(QUARTER)) ? (~kk0 + KK_W'(1)) : kk0;

	// Envelope divisor: zero length counts as one
	logic [LEN_W-1:0] len1;
	assign len1 = (click_length_q == '0) ? LEN_W'(1) : click_length_q;

	// Multiply step: add the sine magnitude when the low multiplier bit is set
	logic [MAG_IN_W:0] mul_sum;
	assign mul_sum = {1'b0, prod_q[MAG_W-1:LEN_W]}
		+ (prod_q[0] ? {1'b0, sine_mag_q} : '0);

	// Rounded numerator reduced by the power-of-two part of the divisor
	logic [NUM_W-1:0] num;
	logic [NH_W-1:0]  num_hi;
	assign num    = NUM_W'({prod_q, {Q_SHIFT{1'b0}}}) + (NUM_W'(len1) << SAMPLE_BITS);
	assign num_hi = num[NUM_W-1 -: NH_W];

	// Divide step: one quotient bit per cycle
	logic [LEN_W:0] div_try;
	logic           div_ge;
	assign div_try = {div_rem_q, div_sh_q[QUO_W-1]};
	assign div_ge  = (div_try >= {1'b0, len1});

	// Saturate and apply the sign
	logic [QUO_W-1:0]        quo_sat;
	logic signed [OUT_W-1:0] sample_val;
	assign quo_sat    = (ovf_q || (div_sh_q > OUT_LIMIT)) ? OUT_LIMIT : div_sh_q;
	assign sample_val = sine_neg_q ? -$signed(OUT_W'(quo_sat)) : $signed(OUT_W'(quo_sat));

	assign snd_next = trigger ? (click_length_q != '0) : (samples_rem_q != '0);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = snd_next ? ST_LOOK : ST_DONE;
				end
			end
			ST_LOOK: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				if (cnt_q == MUL_LAST) begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Handshake outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_free = !out_valid_q || out_ready;
		out_load = (state_q == ST_DONE) && out_free;
	end

	assign in_accept    = in_valid && in_ready;
	assign out_valid    = out_valid_q;
	assign click_sample = click_sample_q;
	assign sounding     = sounding_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_length_q <= CLICK_LENGTH_RST;
			normal_inc_q   <= NORMAL_INCREMENT_RST;
			accent_inc_q   <= ACCENT_INCREMENT_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_CLICK_LENGTH: click_length_q <= cfg_data[LEN_W-1:0];
				REG_NORMAL_INC:   normal_inc_q   <= cfg_data[INC_W-1:0];
				REG_ACCENT_INC:   accent_inc_q   <= cfg_data[INC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Control state, tick state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			item_snd_q    <= 1'b0;
			samples_rem_q <= '0;
			phase_q       <= '0;
			active_inc_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			// Restart the tick on a trigger
			if (in_accept) begin
				item_snd_q <= snd_next;
				if (trigger) begin
					samples_rem_q <= click_length_q;
					phase_q       <= '0;
					active_inc_q  <= accent ? accent_inc_q : normal_inc_q;
				end
			end
			// Advance phase and count once the sample is captured
			if (state_q == ST_LOOK) begin
				phase_q       <= phase_q + PHASE_BITS'(active_inc_q);
				samples_rem_q <= samples_rem_q - LEN_W'(1);
			end
			// Step counter for multiply and divide
			if ((state_q == ST_LOOK) || (state_q == ST_NORM)) begin
				cnt_q <= '0;
			end else if ((state_q == ST_MUL) || (state_q == ST_DIV)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			// Hold the result until taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath and output payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOOK: begin
				sine_mag_q <= qtab[kk];
				sine_neg_q <= sine_addr[SINE_ADDR_BITS-1];
				prod_q     <= MAG_W'(samples_rem_q);
			end
			ST_MUL: begin
				prod_q <= {mul_sum, prod_q[LEN_W-1:1]};
			end
			ST_NORM: begin
				ovf_q     <= (num_hi[NH_W-1:QUO_W] >= len1);
				div_rem_q <= num_hi[NH_W-1:QUO_W];
				div_sh_q  <= num_hi[QUO_W-1:0];
			end
			ST_DIV: begin
				div_rem_q <= div_ge ? LEN_W'(div_try - {1'b0, len1}) : div_try[LEN_W-1:0];
				div_sh_q  <= {div_sh_q[QUO_W-2:0], div_ge};
			end
			default: begin
			end
		endcase
		if (out_load) begin
			click_sample_q <= item_snd_q ? sample_val : '0;
			sounding_q     <= item_snd_q;
		end
	end

endmodule

@@ hw/rtl/mcs_checker.sv @@
// Port-level checker for the metronome click synthesizer, bound to the top level.
module mcs_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [mcs_pkg::OUT_W-1:0]   click_sample,
	input logic                               sounding
);
	import mcs_pkg::*;

	// Track items taken in but not yet delivered
	logic [1:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
		end
	end

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(click_sample) && $stable(sounding))
		else $error("result changed while stalled");

	// No result without an item behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without an accepted item");

	// At most one item in work and one waiting
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many items outstanding");

	// Silent results are zero, and every result stays within the output limit
	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sounding |-> click_sample == '0)
		else $error("nonzero sample while silent");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (click_sample <= $signed({1'b0, OUT_LIMIT}))
			&& (click_sample >= -$signed({1'b0, OUT_LIMIT})))
		else $error("sample out of range");

endmodule

bind metronome_click_synth mcs_checker u_mcs_checker (.*);

@@ tb/tb.sv @@
// Self-checking testbench for the metronome click synthesizer.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mcs_pkg::*;

	localparam int HOLD_CYCLES    = 400;
	localparam int STALL_LIMIT    = 3000;
	localparam int SETTLE_CYCLES  = 40;

	typedef struct packed {
		logic signed [OUT_W-1:0] sample;
		logic                    snd;
	} click_t;

	// Idling patterns for the sender and the receiver
	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	// Tracks the synth state and holds the click samples still owed by the block
	class click_checker;
		int            sine_lut[1024];
		logic [15:0]   len_reg;
		logic [31:0]   norm_inc;
		logic [31:0]   acc_inc;
		logic [15:0]   remaining;
		logic [31:0]   phase;
		logic [31:0]   step;
		click_t        expected_clicks[$];
		int            errors;

		function new();
			build_sine();
			len_reg   = CLICK_LENGTH_RST;
			norm_inc  = NORMAL_INCREMENT_RST;
			acc_inc   = ACCENT_INCREMENT_RST;
			remaining = '0;
			phase     = '0;
			step      = '0;
			errors    = 0;
		endfunction

		// Full-wave table from a Q30 Taylor series on the quarter wave
		function void build_sine();
			longint unsigned x, x2, t, pos, neg, s, v;
			int unsigned     kk;
			bit              lower_half;
			for (int k = 0; k < 1024; k++) begin
				kk = k % 512;
				lower_half = (k >= 512);
				if (kk > 256) begin
					kk = 512 - kk;
				end
				x   = (longint'(kk) * HALF_PI_Q30 + 64'd128) / 64'd256;
				x2  = (x * x) >> 30;
				t   = x;
				pos = x;
				neg = 0;
				for (int n = 1; n <= 4; n++) begin
					t = ((t * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
					if (n % 2 == 1) begin
						neg += t;
					end else begin
						pos += t;
					end
				end
				s = (pos > neg) ? pos - neg : 0;
				v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
				if (v > 32767) begin
					v = 32767;
				end
				sine_lut[k] = lower_half ? -int'(v) : int'(v);
			end
		endfunction

		function void set_config(logic [15:0] len, logic [31:0] ninc, logic [31:0] ainc);
			len_reg  = len;
			norm_inc = ninc;
			acc_inc  = ainc;
		endfunction

		function int pending();
			return expected_clicks.size();
		endfunction

		// Advance the synth by one sample and queue its output
		function void note_input(bit trig, bit acc);
			longint unsigned mag, den, q;
			int              s;
			click_t          c;
			if (trig) begin
				remaining = len_reg;
				phase     = '0;
				step      = acc ? acc_inc : norm_inc;
			end
			c.sample = '0;
			c.snd    = 1'b0;
			if (remaining != 0) begin
				s   = sine_lut[phase[31:22]];
				mag = 64'((s < 0) ? -s : s);
				mag = mag * remaining;
				den = (len_reg == 16'd0) ? 64'd1 : 64'(len_reg);
				den = den << 17;
				q   = ((mag << 15) + den / 2) / den;
				if (q > OUT_LIMIT) begin
					q = OUT_LIMIT;
				end
				c.sample = q[OUT_W-1:0];
				if (s < 0) begin
					c.sample = -c.sample;
				end
				c.snd     = 1'b1;
				phase     = phase + step;
				remaining = remaining - 16'd1;
			end
			expected_clicks.push_back(c);
		endfunction

		task report_mismatch(string msg);
			$display("ERROR at %0t ns: %s", $time, msg);
			errors++;
		endtask

		// Compare one output item against the oldest queued sample
		task check_result(logic signed [OUT_W-1:0] sample, logic snd);
			click_t want;
			if (expected_clicks.size() == 0) begin
				report_mismatch($sformatf("unexpected output item sample=%0d sounding=%b",
					sample, snd));
				return;
			end
			want = expected_clicks.pop_front();
			if (sample !== want.sample) begin
				report_mismatch($sformatf("click_sample got %0d, expected %0d",
					sample, want.sample));
			end
			if (snd !== want.snd) begin
				report_mismatch($sformatf("sounding got %b, expected %b", snd, want.snd));
			end
		endtask
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic                    trigger;
	logic                    accent;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [OUT_W-1:0] click_sample;
	logic                    sounding;

	click_checker click_chk;
	int           send_idle_pct  = 0;
	int           recv_stall_pct = 0;
	bit           hold_pending   = 1'b0;
	int           quiet_cycles   = 0;

	metronome_click_synth i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.trigger      (trigger),
		.accent       (accent),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.click_sample (click_sample),
		.sounding     (sounding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check every output item taken
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			click_chk.check_result(click_sample, sounding);
		end
	end

	// Drive out_ready: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// End the run if no item moves on either side for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("metronome_click_synth: mismatch");
				$finish;
			end
		end
	end

	// Offer one sample item, idling first at random, and hold it until taken
	task automatic send_sample(bit trig, bit acc);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		trigger  <= trig;
		accent   <= acc;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		click_chk.note_input(trig, acc);
	endtask

	// Drop valid and wait for every owed output item
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (click_chk.pending() != 0);
	endtask

	task automatic configure(logic [15:0] len, logic [31:0] ninc, logic [31:0] ainc);
		cfg_we    <= 1'b1;
		cfg_index <= REG_CLICK_LENGTH;
		cfg_data  <= {16'd0, len};
		@(posedge clk);
		cfg_index <= REG_NORMAL_INC;
		cfg_data  <= ninc;
		@(posedge clk);
		cfg_index <= REG_ACCENT_INC;
		cfg_data  <= ainc;
		@(posedge clk);
		cfg_we    <= 1'b0;
		click_chk.set_config(len, ninc, ainc);
	endtask

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_SEND: begin
				send_idle_pct  = 83;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct  = 0;
				recv_stall_pct = 83;
			end
			IDLE_BOTH: begin
				send_idle_pct  = 19;
				recv_stall_pct = 19;
			end
			default: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	// One random stretch under a fixed setting; ends with the block empty
	task automatic run_phase(logic [15:0] len, logic [31:0] ninc, logic [31:0] ainc,
			idle_mode_t mode, int n_items, int trig_pct, bit hold);
		configure(len, ninc, ainc);
		set_idling(mode);
		if (hold) begin
			hold_pending = 1'b1;
		end
		for (int i = 0; i < n_items; i++) begin
			send_sample($urandom_range(99) < trig_pct, 1'($urandom_range(1)));
			if ($urandom_range(59) == 0) begin
				drain();
			end
		end
		drain();
	endtask

	initial begin
		click_chk = new();
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_CLICK_LENGTH;
		cfg_data  = '0;
		in_valid  = 1'b0;
		trigger   = 1'b0;
		accent    = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Silence before any tick, then a normal tick and an accented retrigger
		send_sample(1'b0, 1'b0);
		send_sample(1'b0, 1'b1);
		send_sample(1'b1, 1'b0);
		repeat (4) send_sample(1'b0, 1'b0);
		send_sample(1'b1, 1'b1);
		repeat (3) send_sample(1'b0, 1'b1);
		drain();

		// Shrink length to zero under a sounding tick, then trigger a zero-length tick
		configure(16'd0, 32'd0, 32'hFFFF_FFFF);
		send_sample(1'b0, 1'b0);
		send_sample(1'b0, 1'b0);
		send_sample(1'b1, 1'b1);
		send_sample(1'b0, 1'b0);
		drain();

		// One-sample ticks with extreme steps
		configure(16'd1, 32'hFFFF_FFFF, 32'd0);
		send_sample(1'b1, 1'b0);
		send_sample(1'b0, 1'b0);
		send_sample(1'b1, 1'b1);
		send_sample(1'b0, 1'b1);
		send_sample(1'b1, 1'b0);
		drain();

		// Longest tick
		configure(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(1'b1, 1'b1);
		send_sample(1'b0, 1'b0);
		send_sample(1'b1, 1'b0);
		send_sample(1'b0, 1'b1);
		drain();

		// Random stretches across settings and idling patterns
		run_phase(16'd24, $urandom, $urandom, IDLE_NONE, 160, 6, 1'b1);
		run_phase(16'hFFFF, 32'hFFFF_FFFF, $urandom, IDLE_SEND, 120, 3, 1'b0);
		run_phase(16'($urandom_range(2, 16)), $urandom, $urandom, IDLE_RECV, 170, 10, 1'b0);
		run_phase(16'd1, 32'd0, 32'hFFFF_FFFF, IDLE_BOTH, 120, 30, 1'b0);
		run_phase(16'd0, $urandom, $urandom, IDLE_SEND, 60, 20, 1'b0);
		run_phase(16'($urandom_range(8, 64)), NORMAL_INCREMENT_RST, ACCENT_INCREMENT_RST,
			IDLE_RECV, 170, 4, 1'b0);
		run_phase(16'($urandom_range(2, 40)), $urandom, $urandom, IDLE_BOTH, 180, 5, 1'b1);
		run_phase(CLICK_LENGTH_RST, NORMAL_INCREMENT_RST, ACCENT_INCREMENT_RST,
			IDLE_NONE, 145, 1, 1'b0);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (click_chk.errors == 0) begin
			$display("metronome_click_synth: match");
		end else begin
			$display("metronome_click_synth: mismatch");
		end
		$finish;
	end

endmodule
